// ===== hdl/gtss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtss_pkg: shared types, constants and tables for the glyph tone synth
// Request and sample structs, register indexes, state codes, the 8x8 font
// and the sine table entry function.
// ----------------------------------------------------------------------------
package gtss_pkg;

	localparam int NUM_COPIES_DEF = 4;
	localparam int NUM_ROWS       = 8;
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int FONT_DEPTH     = 768;
	localparam int GAIN_W         = 40;
	localparam int GAIN_CHUNK     = 10;
	localparam int GAIN_CHUNKS    = GAIN_W / GAIN_CHUNK;
	localparam int QUO_W          = 16;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [31:0] BASE_STEP_RST      = 32'd1558264779;
	localparam logic [31:0] ROW_STEP_RST       = 32'd48695774;
	localparam logic [31:0] COPY_STEP_RST      = 32'd12173944;
	localparam logic [15:0] PIXEL_WIDTH_RST    = 16'd11025;
	localparam logic [15:0] FADE_IN_END_RST    = 16'd2757;
	localparam logic [15:0] FADE_OUT_START_RST = 16'd8268;
	localparam logic [23:0] FADE_SLOPE_RST     = 24'd6152;
	localparam logic [7:0]  CHAR_FIRST         = 8'd32;
	localparam logic [7:0]  CHAR_LAST          = 8'd127;

	typedef enum logic [0:0] {
		REQ_LOAD = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		REG_BASE_STEP,
		REG_ROW_STEP,
		REG_COPY_STEP,
		REG_PIXEL_WIDTH,
		REG_FADE_IN_END,
		REG_FADE_OUT_START,
		REG_FADE_SLOPE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_OSC,
		ST_SCALE,
		ST_MUL,
		ST_CLAMP,
		ST_DIV,
		ST_DONE
	} gtss_state_t;

	typedef struct packed {
		logic [0:0] req_type;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic signed [15:0] audio_out;
		logic               active;
		logic               glyph_last;
	} smp_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scale;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic finish;
	} gtss_cmd_t;

	typedef struct packed {
		logic busy;
		logic osc_done;
		logic mul_done;
		logic div_done;
		logic out_free;
	} gtss_sts_t;

	typedef logic [7:0] font_rom_t [FONT_DEPTH];

	localparam font_rom_t FONT_ROM = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h18, 8'h18,
		8'h00, 8'h00, 8'h18, 8'h00, 8'h66, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h66, 8'h66, 8'hff, 8'h66, 8'hff, 8'h66, 8'h66, 8'h00, 8'h18, 8'h3e, 8'h60, 8'h3c,
		8'h06, 8'h7c, 8'h18, 8'h00, 8'h62, 8'h66, 8'h0c, 8'h18, 8'h30, 8'h66, 8'h46, 8'h00,
		8'h3c, 8'h66, 8'h3c, 8'h38, 8'h67, 8'h66, 8'h3f, 8'h00, 8'h06, 8'h0c, 8'h18, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h0c, 8'h18, 8'h30, 8'h30, 8'h30, 8'h18, 8'h0c, 8'h00,
		8'h30, 8'h18, 8'h0c, 8'h0c, 8'h0c, 8'h18, 8'h30, 8'h00, 8'h00, 8'h66, 8'h3c, 8'hff,
		8'h3c, 8'h66, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h7e, 8'h18, 8'h18, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h30, 8'h00, 8'h00, 8'h00, 8'h7e,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h00,
		8'h00, 8'h03, 8'h06, 8'h0c, 8'h18, 8'h30, 8'h60, 8'h00, 8'h3c, 8'h66, 8'h6e, 8'h76,
		8'h66, 8'h66, 8'h3c, 8'h00, 8'h18, 8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h7e, 8'h00,
		8'h3c, 8'h66, 8'h06, 8'h0c, 8'h30, 8'h60, 8'h7e, 8'h00, 8'h3c, 8'h66, 8'h06, 8'h1c,
		8'h06, 8'h66, 8'h3c, 8'h00, 8'h06, 8'h0e, 8'h1e, 8'h66, 8'h7f, 8'h06, 8'h06, 8'h00,
		8'h7e, 8'h60, 8'h7c, 8'h06, 8'h06, 8'h66, 8'h3c, 8'h00, 8'h3c, 8'h66, 8'h60, 8'h7c,
		8'h66, 8'h66, 8'h3c, 8'h00, 8'h7e, 8'h66, 8'h0c, 8'h18, 8'h18, 8'h18, 8'h18, 8'h00,
		8'h3c, 8'h66, 8'h66, 8'h3c, 8'h66, 8'h66, 8'h3c, 8'h00, 8'h3c, 8'h66, 8'h66, 8'h3e,
		8'h06, 8'h66, 8'h3c, 8'h00, 8'h00, 8'h00, 8'h18, 8'h00, 8'h00, 8'h18, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h18, 8'h00, 8'h00, 8'h18, 8'h18, 8'h30, 8'h0e, 8'h18, 8'h30, 8'h60,
		8'h30, 8'h18, 8'h0e, 8'h00, 8'h00, 8'h00, 8'h7e, 8'h00, 8'h7e, 8'h00, 8'h00, 8'h00,
		8'h70, 8'h18, 8'h0c, 8'h06, 8'h0c, 8'h18, 8'h70, 8'h00, 8'h3c, 8'h66, 8'h06, 8'h0c,
		8'h18, 8'h00, 8'h18, 8'h00, 8'h3c, 8'h66, 8'h6e, 8'h6e, 8'h60, 8'h62, 8'h3c, 8'h00,
		8'h18, 8'h3c, 8'h66, 8'h7e, 8'h66, 8'h66, 8'h66, 8'h00, 8'h7c, 8'h66, 8'h66, 8'h7c,
		8'h66, 8'h66, 8'h7c, 8'h00, 8'h3c, 8'h66, 8'h60, 8'h60, 8'h60, 8'h66, 8'h3c, 8'h00,
		8'h78, 8'h6c, 8'h66, 8'h66, 8'h66, 8'h6c, 8'h78, 8'h00, 8'h7e, 8'h60, 8'h60, 8'h78,
		8'h60, 8'h60, 8'h7e, 8'h00, 8'h7e, 8'h60, 8'h60, 8'h78, 8'h60, 8'h60, 8'h60, 8'h00,
		8'h3c, 8'h66, 8'h60, 8'h6e, 8'h66, 8'h66, 8'h3c, 8'h00, 8'h66, 8'h66, 8'h66, 8'h7e,
		8'h66, 8'h66, 8'h66, 8'h00, 8'h3c, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3c, 8'h00,
		8'h1e, 8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'h6c, 8'h38, 8'h00, 8'h66, 8'h6c, 8'h78, 8'h70,
		8'h78, 8'h6c, 8'h66, 8'h00, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h7e, 8'h00,
		8'h63, 8'h77, 8'h7f, 8'h6b, 8'h63, 8'h63, 8'h63, 8'h00, 8'h66, 8'h76, 8'h7e, 8'h7e,
		8'h6e, 8'h66, 8'h66, 8'h00, 8'h3c, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3c, 8'h00,
		8'h7c, 8'h66, 8'h66, 8'h7c, 8'h60, 8'h60, 8'h60, 8'h00, 8'h3c, 8'h66, 8'h66, 8'h66,
		8'h66, 8'h3c, 8'h0e, 8'h00, 8'h7c, 8'h66, 8'h66, 8'h7c, 8'h78, 8'h6c, 8'h66, 8'h00,
		8'h3c, 8'h66, 8'h60, 8'h3c, 8'h06, 8'h66, 8'h3c, 8'h00, 8'h7e, 8'h18, 8'h18, 8'h18,
		8'h18, 8'h18, 8'h18, 8'h00, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3c, 8'h00,
		8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3c, 8'h18, 8'h00, 8'h63, 8'h63, 8'h63, 8'h6b,
		8'h7f, 8'h77, 8'h63, 8'h00, 8'h66, 8'h66, 8'h3c, 8'h18, 8'h3c, 8'h66, 8'h66, 8'h00,
		8'h66, 8'h66, 8'h66, 8'h3c, 8'h18, 8'h18, 8'h18, 8'h00, 8'h7e, 8'h06, 8'h0c, 8'h18,
		8'h30, 8'h60, 8'h7e, 8'h00, 8'h3c, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h3c, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3c, 8'h0c, 8'h0c, 8'h0c,
		8'h0c, 8'h0c, 8'h3c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3c, 8'h06, 8'h3e, 8'h66, 8'h3e, 8'h00,
		8'h00, 8'h60, 8'h60, 8'h7c, 8'h66, 8'h66, 8'h7c, 8'h00, 8'h00, 8'h00, 8'h3c, 8'h60,
		8'h60, 8'h60, 8'h3c, 8'h00, 8'h00, 8'h06, 8'h06, 8'h3e, 8'h66, 8'h66, 8'h3e, 8'h00,
		8'h00, 8'h00, 8'h3c, 8'h66, 8'h7e, 8'h60, 8'h3c, 8'h00, 8'h00, 8'h0e, 8'h18, 8'h3e,
		8'h18, 8'h18, 8'h18, 8'h00, 8'h00, 8'h00, 8'h3e, 8'h66, 8'h66, 8'h3e, 8'h06, 8'h7c,
		8'h00, 8'h60, 8'h60, 8'h7c, 8'h66, 8'h66, 8'h66, 8'h00, 8'h00, 8'h18, 8'h00, 8'h38,
		8'h18, 8'h18, 8'h3c, 8'h00, 8'h00, 8'h06, 8'h00, 8'h06, 8'h06, 8'h06, 8'h06, 8'h3c,
		8'h00, 8'h60, 8'h60, 8'h6c, 8'h78, 8'h6c, 8'h66, 8'h00, 8'h00, 8'h38, 8'h18, 8'h18,
		8'h18, 8'h18, 8'h3c, 8'h00, 8'h00, 8'h00, 8'h66, 8'h7f, 8'h7f, 8'h6b, 8'h63, 8'h00,
		8'h00, 8'h00, 8'h7c, 8'h66, 8'h66, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h3c, 8'h66,
		8'h66, 8'h66, 8'h3c, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h66, 8'h66, 8'h7c, 8'h60, 8'h60,
		8'h00, 8'h00, 8'h3e, 8'h66, 8'h66, 8'h3e, 8'h06, 8'h06, 8'h00, 8'h00, 8'h7c, 8'h66,
		8'h60, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00, 8'h3e, 8'h60, 8'h3c, 8'h06, 8'h7c, 8'h00,
		8'h00, 8'h18, 8'h7e, 8'h18, 8'h18, 8'h18, 8'h0e, 8'h00, 8'h00, 8'h00, 8'h66, 8'h66,
		8'h66, 8'h66, 8'h3e, 8'h00, 8'h00, 8'h00, 8'h66, 8'h66, 8'h66, 8'h3c, 8'h18, 8'h00,
		8'h00, 8'h00, 8'h63, 8'h6b, 8'h7f, 8'h3e, 8'h36, 8'h00, 8'h00, 8'h00, 8'h66, 8'h3c,
		8'h18, 8'h3c, 8'h66, 8'h00, 8'h00, 8'h00, 8'h66, 8'h66, 8'h66, 8'h3e, 8'h0c, 8'h78,
		8'h00, 8'h00, 8'h7e, 8'h0c, 8'h18, 8'h30, 8'h7e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Q1.15 sine of angle t (2^32 = one turn), quadrant folded Taylor series in Q30
	function automatic logic signed [15:0] sine_entry(input logic [31:0] t);
		logic [1:0]  quad;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		quad = t[31:30];
		f    = {34'd0, t[29:0]};
		if (quad[0]) begin
			f = 64'h4000_0000 - f;
		end
		x    = (f * PI_HALF_Q30) >> 30;
		term = x;
		sum  = x;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
		sum  = sum - term;
		v = (sum * 64'd32768 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/gtss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtss_ctrl: sequencing state machine
// Takes one request at a time; a tick while a glyph sounds steps the datapath
// through oscillator sweep, gain multiply, scale divide and result write.
// ----------------------------------------------------------------------------
module gtss_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire logic [0:0]         req_type,
	output logic                    item_stall,
	input  wire gtss_pkg::gtss_sts_t sts,
	output gtss_pkg::gtss_cmd_t     cmd
);
	import gtss_pkg::*;

	gtss_state_t state_q;
	gtss_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && req_type == REQ_TICK) begin
					state_nxt = sts.busy ? ST_PREP : ST_DONE;
				end
			end
			ST_PREP:  state_nxt = ST_OSC;
			ST_OSC:   if (sts.osc_done) state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_MUL;
			ST_MUL:   if (sts.mul_done) state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_DIV;
			ST_DIV:   if (sts.div_done) state_nxt = ST_DONE;
			ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall   = (state_q != ST_IDLE);
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && item_valid && (req_type == REQ_LOAD);
		cmd.start    = (state_q == ST_PREP);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.mul_step = (state_q == ST_MUL);
		cmd.div_init = (state_q == ST_CLAMP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_DONE) && sts.out_free;
	end

endmodule
`default_nettype wire

// ===== hdl/gtss_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtss_dp: registers, glyph counters, oscillator sweep and output scaling
// Sweeps the oscillators one per cycle through the font and sine tables,
// applies the fade gain in chunks, divides by the copy weight with a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module gtss_dp #(
	parameter int NUM_COPIES = gtss_pkg::NUM_COPIES_DEF,
	parameter int SINE_DEPTH = gtss_pkg::SINE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire gtss_pkg::item_t     item,
	input  wire gtss_pkg::gtss_cmd_t cmd,
	output gtss_pkg::gtss_sts_t      sts,
	output logic                     smp_valid,
	input  wire logic                smp_stall,
	output gtss_pkg::smp_t           smp
);
	import gtss_pkg::*;

	localparam int AW    = $clog2(SINE_DEPTH);
	localparam int CW    = (NUM_COPIES > 1) ? $clog2(NUM_COPIES) : 1;
	localparam int NOSC  = NUM_ROWS * NUM_COPIES;
	localparam int ACC_W = $clog2(NUM_ROWS * NUM_COPIES) + 17;
	localparam int B_W   = ACC_W + 15;
	localparam int X_W   = B_W + GAIN_W;
	localparam int QS_W  = X_W - 38;
	localparam int DIV   = 9 * NUM_COPIES;
	localparam int QW    = $clog2(65536 * DIV);
	localparam int RK    = QW + $clog2(DIV);
	localparam int RW    = RK + 1;
	localparam logic [CW-1:0]   C_LAST  = CW'(NUM_COPIES - 1);
	localparam logic [QS_W-1:0] Q_OFS   = QS_W'(32768 * DIV);
	localparam logic [QS_W-1:0] Q_MAX   = QS_W'(65536 * DIV - 1);
	localparam logic [RW-1:0]   RECIP   =
		RW'(((64'd1 << RK) + 64'(DIV) - 64'd1) / 64'(DIV));
	localparam logic [3:0]      MUL_END = 4'(GAIN_CHUNKS - 1);

	logic [31:0] base_step_q;
	logic [31:0] row_step_q;
	logic [31:0] copy_step_q;
	logic [15:0] pixel_width_q;
	logic [15:0] fade_in_end_q;
	logic [15:0] fade_out_start_q;
	logic [23:0] fade_slope_q;

	logic [6:0]  glyph_q;
	logic [2:0]  col_q;
	logic [15:0] sample_q;
	logic        busy_q;

	logic [31:0] ring_q [NOSC];
	logic [GAIN_W-1:0] g_q;
	logic [31:0] rofs_q;
	logic [31:0] cofs_q;
	logic [2:0]  r_q;
	logic [CW-1:0] c_q;
	logic        iss_q;
	logic        v_s1;
	logic [7:0]  font_s1;
	logic signed [15:0] sine_s1;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [B_W-1:0] b_q;
	logic signed [X_W-1:0] x_q;
	logic [GAIN_W-1:0] gsh_q;
	logic [3:0]  stp_q;
	logic [QW-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic        ovalid_q;
	smp_t        smp_q;

	logic signed [15:0] sine_mem [SINE_DEPTH];
	logic [31:0] phase;
	logic [31:0] step_sum;
	logic [15:0] pw_eff;
	logic [16:0] s_next;
	logic        wrap;
	logic [15:0] fade_opnd;
	logic        unity;
	logic signed [QS_W-1:0] qs;
	logic signed [B_W+GAIN_CHUNK:0] part;
	logic [QW+RK:0] quo_full;

	for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_sine
		assign sine_mem[k] = sine_entry(32'(k) << (32 - AW));
	end

	assign phase    = (sample_q == 16'd0) ? 32'd0 : ring_q[0];
	assign step_sum = base_step_q + rofs_q + cofs_q;
	assign pw_eff   = (pixel_width_q == 16'd0) ? 16'd1 : pixel_width_q;
	assign s_next   = {1'b0, sample_q} + 17'd1;
	assign wrap     = (s_next >= {1'b0, pw_eff});
	assign qs       = $signed(x_q[X_W-1:39]) + $signed(Q_OFS);
	assign part     = b_q * $signed({1'b0, gsh_q[GAIN_W-1 -: GAIN_CHUNK]});
	assign quo_full = rem_q * RECIP;

	always_comb begin
		unity     = 1'b0;
		fade_opnd = sample_q;
		if (sample_q < fade_in_end_q) begin
			fade_opnd = sample_q;
		end else if (sample_q > fade_out_start_q) begin
			fade_opnd = (sample_q < pw_eff) ? (pw_eff - sample_q) : 16'd0;
		end else begin
			unity = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q      <= BASE_STEP_RST;
			row_step_q       <= ROW_STEP_RST;
			copy_step_q      <= COPY_STEP_RST;
			pixel_width_q    <= PIXEL_WIDTH_RST;
			fade_in_end_q    <= FADE_IN_END_RST;
			fade_out_start_q <= FADE_OUT_START_RST;
			fade_slope_q     <= FADE_SLOPE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BASE_STEP:      base_step_q      <= cfg_data;
				REG_ROW_STEP:       row_step_q       <= cfg_data;
				REG_COPY_STEP:      copy_step_q      <= cfg_data;
				REG_PIXEL_WIDTH:    pixel_width_q    <= cfg_data[15:0];
				REG_FADE_IN_END:    fade_in_end_q    <= cfg_data[15:0];
				REG_FADE_OUT_START: fade_out_start_q <= cfg_data[15:0];
				REG_FADE_SLOPE:     fade_slope_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// glyph position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_q  <= '0;
			col_q    <= '0;
			sample_q <= '0;
			busy_q   <= 1'b0;
		end else if (cmd.load) begin
			if (!busy_q && item.char_code >= CHAR_FIRST && item.char_code <= CHAR_LAST) begin
				glyph_q  <= 7'(item.char_code - CHAR_FIRST);
				col_q    <= '0;
				sample_q <= '0;
				busy_q   <= 1'b1;
			end
		end else if (cmd.finish && busy_q) begin
			if (wrap) begin
				sample_q <= '0;
				col_q    <= col_q + 3'd1;
				if (col_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end else begin
				sample_q <= s_next[15:0];
			end
		end
	end

	// oscillator sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= 1'b0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= iss_q;
			if (cmd.start) begin
				iss_q <= 1'b1;
			end else if (iss_q && c_q == C_LAST && r_q == 3'd7) begin
				iss_q <= 1'b0;
			end
		end
	end

	// rotate the phase ring, one oscillator per cycle
	always_ff @(posedge clk) begin
		if (iss_q) begin
			for (int k = 0; k < NOSC - 1; k++) begin
				ring_q[k] <= ring_q[k + 1];
			end
			ring_q[NOSC - 1] <= phase + step_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			g_q    <= unity ? GAIN_W'(1 << 24) : GAIN_W'(fade_slope_q * fade_opnd);
			rofs_q <= '0;
			cofs_q <= '0;
			r_q    <= '0;
			c_q    <= '0;
			acc_q  <= '0;
		end else begin
			if (iss_q) begin
				if (c_q == C_LAST) begin
					c_q    <= '0;
					cofs_q <= '0;
					rofs_q <= rofs_q + row_step_q;
					r_q    <= r_q + 3'd1;
				end else begin
					c_q    <= c_q + CW'(1);
					cofs_q <= cofs_q + copy_step_q;
				end
			end
			if (v_s1 && font_s1[~col_q]) begin
				acc_q <= acc_q + ACC_W'(sine_s1);
			end
		end
		font_s1 <= FONT_ROM[{glyph_q, ~r_q}];
		sine_s1 <= sine_mem[phase[31 -: AW]];
	end

	// gain multiply and scale divide
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			b_q   <= (B_W'(acc_q) <<< 15) - B_W'(acc_q);
			x_q   <= '0;
			gsh_q <= g_q;
			stp_q <= '0;
		end else if (cmd.mul_step) begin
			x_q   <= (x_q <<< GAIN_CHUNK) + X_W'(part);
			gsh_q <= gsh_q << GAIN_CHUNK;
			stp_q <= stp_q + 4'd1;
		end else if (cmd.div_init) begin
			if (qs < 0) begin
				rem_q <= '0;
			end else if (qs > $signed(Q_MAX)) begin
				rem_q <= QW'(Q_MAX);
			end else begin
				rem_q <= qs[QW-1:0];
			end
			quo_q <= '0;
			stp_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_full[RK +: QUO_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.finish) begin
			ovalid_q <= 1'b1;
		end else if (!smp_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			smp_q.audio_out  <= busy_q ? $signed({~quo_q[QUO_W-1], quo_q[QUO_W-2:0]}) : '0;
			smp_q.active     <= busy_q;
			smp_q.glyph_last <= busy_q && wrap && (col_q == 3'd7);
		end
	end

	always_comb begin
		sts.busy     = busy_q;
		sts.osc_done = !iss_q && !v_s1;
		sts.mul_done = (stp_q == MUL_END);
		sts.div_done = 1'b1;
		sts.out_free = !ovalid_q || !smp_stall;
	end

	assign smp_valid = ovalid_q;
	assign smp       = smp_q;

endmodule
`default_nettype wire

// ===== hdl/glyph_to_sine_bank_synth_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_to_sine_bank_synth_unit: glyph to spectrogram tone synthesizer
// Load requests pick a glyph (ignored while one sounds or if the code is out of range);
// tick requests return one audio sample each.
// Load request: no sample. Tick while idle: goes straight to the result write.
// Tick while sounding: runs the one-oscillator-per-cycle sweep, the 4-step gain
// multiply, the clamp and the reciprocal divide before the result write.
// One request in flight; the sample register lets a finished sample wait.
// Async reset clears registers to defaults and returns to no glyph sounding.
module glyph_to_sine_bank_synth_unit #(
	parameter int NUM_COPIES = gtss_pkg::NUM_COPIES_DEF,
	parameter int SINE_DEPTH = gtss_pkg::SINE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [31:0]     cfg_data,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire gtss_pkg::item_t item,
	output logic                 smp_valid,
	input  wire logic            smp_stall,
	output gtss_pkg::smp_t       smp
);
	import gtss_pkg::*;

	gtss_cmd_t cmd;
	gtss_sts_t sts;

	assign cfg_ready = 1'b1;

	gtss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.req_type   (item.req_type),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	gtss_dp #(
		.NUM_COPIES (NUM_COPIES),
		.SINE_DEPTH (SINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

endmodule
`default_nettype wire

// ===== bench/glyph_to_sine_bank_synth_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_to_sine_bank_synth_unit_tb: self-checking bench for the glyph synth
// Sends load and tick requests with random gaps and output back-pressure,
// predicts every sample from its own oscillator bank, fade and scaling
// arithmetic, and compares each returned sample field by field.
// ----------------------------------------------------------------------------
module glyph_to_sine_bank_synth_unit_tb;
	import gtss_pkg::*;

	localparam int NCOPY   = NUM_COPIES_DEF;
	localparam int NOSC    = NUM_ROWS * NCOPY;
	localparam int WD_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        smp_valid;
	logic        smp_stall;
	smp_t        smp;

	glyph_to_sine_bank_synth_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.smp_valid(smp_valid), .smp_stall(smp_stall), .smp(smp)
	);

	// predictor state
	logic [31:0] base_step, row_step, copy_step;
	logic [15:0] pixel_width, fade_in_end, fade_out_start;
	logic [23:0] fade_slope;
	logic [6:0]  glyph_sel;
	logic [2:0]  col_cnt;
	logic [15:0] smp_cnt;
	logic        sounding;
	logic [31:0] phase_acc [NOSC];
	int          sine_lut [1024];

	smp_t        sample_q [$];
	int          err_cnt;
	int          n_loads, n_ticks, n_samples, n_glyphs;
	int          send_idle_pct, recv_idle_pct;
	int          hold_cycles;
	int          quiet_cycles;

	function automatic int sine_value(input logic [31:0] t);
		longint unsigned f, x, term, acc, v;
		int n;
		f = t[29:0];
		if (t[30]) f = 64'h4000_0000 - f;
		x = (f * 64'd1686629713) >> 30;
		term = x;
		acc = x;
		for (n = 1; n <= 7; n++) begin
			term = ((((term * x) >> 30) * x) >> 30) / (2 * n * (2 * n + 1));
			if (n % 2) acc = acc - term;
			else acc = acc + term;
		end
		v = (acc * 32768 + (64'd1 << 29)) >> 30;
		if (v > 32767) v = 32767;
		return t[31] ? -int'(v) : int'(v);
	endfunction

	function automatic longint fdiv(input longint num, input longint den);
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic void reset_model();
		base_step      = BASE_STEP_RST;
		row_step       = ROW_STEP_RST;
		copy_step      = COPY_STEP_RST;
		pixel_width    = PIXEL_WIDTH_RST;
		fade_in_end    = FADE_IN_END_RST;
		fade_out_start = FADE_OUT_START_RST;
		fade_slope     = FADE_SLOPE_RST;
		glyph_sel = '0;
		col_cnt   = '0;
		smp_cnt   = '0;
		sounding  = 1'b0;
		foreach (phase_acc[i]) phase_acc[i] = '0;
	endfunction

	function automatic void load_glyph(input logic [7:0] code);
		if (!sounding && code >= CHAR_FIRST && code <= CHAR_LAST) begin
			glyph_sel = code - CHAR_FIRST;
			col_cnt   = '0;
			smp_cnt   = '0;
			sounding  = 1'b1;
			foreach (phase_acc[i]) phase_acc[i] = '0;
		end
	endfunction

	function automatic smp_t synth_tick();
		smp_t        res;
		logic [31:0] pw, s, fade_dist, stp;
		logic [7:0]  row_bits;
		longint      acc, b, part, y;
		longint unsigned gain, gh, gl;
		int          idx;
		res = '0;
		if (!sounding) return res;
		pw = (pixel_width == 0) ? 32'd1 : {16'd0, pixel_width};
		s = {16'd0, smp_cnt};
		acc = 0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			row_bits = FONT_ROM[int'(glyph_sel) * 8 + (7 - r)];
			for (int c = 0; c < NCOPY; c++) begin
				idx = r * NCOPY + c;
				stp = base_step + r * row_step + c * copy_step;
				if (row_bits[7 - col_cnt]) acc += sine_lut[phase_acc[idx][31:22]];
				phase_acc[idx] = phase_acc[idx] + stp;
			end
		end
		if (s < fade_in_end) begin
			gain = longint'(fade_slope) * s;
		end else if (s > fade_out_start) begin
			fade_dist = (s < pw) ? pw - s : 32'd0;
			gain = longint'(fade_slope) * fade_dist;
		end else begin
			gain = 64'd1 << 24;
		end
		gh = gain >> 24;
		gl = gain & 64'hFF_FFFF;
		b = acc * 32767;
		part = fdiv(b * longint'(gl), 64'sd1 << 24) + b * longint'(gh);
		y = fdiv(part, NCOPY * 9 * 32768);
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		res.audio_out = y[15:0];
		res.active = 1'b1;
		s = s + 1;
		if (s >= pw) begin
			smp_cnt = '0;
			foreach (phase_acc[i]) phase_acc[i] = '0;
			if (col_cnt == 3'd7) begin
				res.glyph_last = 1'b1;
				sounding = 1'b0;
				col_cnt = '0;
			end else begin
				col_cnt = col_cnt + 1;
			end
		end else begin
			smp_cnt = s[15:0];
		end
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_req(input req_kind_t kind, input logic [7:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= {kind, code};
		do @(posedge clk); while (item_stall);
		if (kind == REQ_LOAD) begin
			n_loads++;
			load_glyph(code);
		end else begin
			n_ticks++;
			sample_q.push_back(synth_tick());
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (sample_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BASE_STEP:      base_step = val;
			REG_ROW_STEP:       row_step = val;
			REG_COPY_STEP:      copy_step = val;
			REG_PIXEL_WIDTH:    pixel_width = val[15:0];
			REG_FADE_IN_END:    fade_in_end = val[15:0];
			REG_FADE_OUT_START: fade_out_start = val[15:0];
			REG_FADE_SLOPE:     fade_slope = val[23:0];
			default: ;
		endcase
	endtask

	task automatic play_glyph(input logic [7:0] code, input int extra);
		int pw;
		pw = (pixel_width == 0) ? 1 : pixel_width;
		send_req(REQ_LOAD, code);
		repeat (8 * pw + extra) send_req(REQ_TICK, 8'($urandom_range(255)));
	endtask

	task automatic test_directed();
		send_req(REQ_TICK, 8'hFF);
		send_req(REQ_LOAD, 8'd0);
		send_req(REQ_LOAD, 8'd31);
		send_req(REQ_LOAD, 8'd128);
		send_req(REQ_LOAD, 8'd255);
		send_req(REQ_TICK, 8'h00);
		write_reg(REG_PIXEL_WIDTH, 32'd2);
		write_reg(REG_FADE_IN_END, 32'd1);
		write_reg(REG_FADE_OUT_START, 32'd0);
		write_reg(REG_FADE_SLOPE, 32'hFF_FFFF);
		send_req(REQ_LOAD, 8'd32);
		send_req(REQ_TICK, 8'h00);
		send_req(REQ_LOAD, 8'd127);
		repeat (16) send_req(REQ_TICK, 8'hFF);
		write_reg(REG_PIXEL_WIDTH, 32'd0);
		write_reg(REG_BASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_ROW_STEP, 32'd0);
		write_reg(REG_COPY_STEP, 32'hFFFF_FFFF);
		write_reg(REG_FADE_IN_END, 32'hFFFF);
		write_reg(REG_FADE_OUT_START, 32'hFFFF);
		play_glyph(8'd35, 2);
		write_reg(REG_BASE_STEP, 32'd0);
		write_reg(REG_FADE_IN_END, 32'd0);
		write_reg(REG_FADE_SLOPE, 32'd0);
		play_glyph(8'd87, 0);
	endtask

	task automatic test_width_shrink();
		write_reg(REG_PIXEL_WIDTH, 32'hFFFF);
		write_reg(REG_FADE_IN_END, 32'd2);
		write_reg(REG_FADE_OUT_START, 32'd1);
		write_reg(REG_FADE_SLOPE, 32'd6152);
		send_req(REQ_LOAD, 8'd64);
		repeat (5) send_req(REQ_TICK, 8'h00);
		write_reg(REG_PIXEL_WIDTH, 32'd1);
		repeat (9) send_req(REQ_TICK, 8'h00);
	endtask

	task automatic test_backpressure();
		write_reg(REG_PIXEL_WIDTH, 32'd8);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_req(REQ_LOAD, 8'd65);
		hold_cycles = 400;
		repeat (40) send_req(REQ_TICK, 8'h55);
	endtask

	task automatic test_random(input int n_items, input int s_pct, input int r_pct,
			input int max_pw);
		int start, sel;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_reg(REG_BASE_STEP, $urandom);
		write_reg(REG_ROW_STEP, $urandom);
		write_reg(REG_COPY_STEP, $urandom);
		write_reg(REG_PIXEL_WIDTH, $urandom_range(max_pw, 1));
		write_reg(REG_FADE_IN_END, $urandom_range(max_pw + 1));
		write_reg(REG_FADE_OUT_START, $urandom_range(max_pw));
		write_reg(REG_FADE_SLOPE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 22));
		start = n_loads + n_ticks;
		while (n_loads + n_ticks - start < n_items) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				send_req(REQ_LOAD, 8'($urandom_range(127, 32)));
				for (int k = 8 * pixel_width + $urandom_range(2); k > 0; k--) begin
					if ($urandom_range(19) == 0) send_req(REQ_LOAD, 8'($urandom_range(255)));
					send_req(REQ_TICK, 8'($urandom_range(255)));
				end
			end else if (sel < 85) begin
				send_req(REQ_LOAD, 8'($urandom_range(255)));
			end else begin
				send_req(REQ_TICK, 8'($urandom_range(255)));
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			smp_stall <= 1'b1;
		end else begin
			smp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		smp_t want;
		if (arst_n && smp_valid && !smp_stall) begin
			n_samples++;
			if (sample_q.size() == 0) begin
				$error("sample with none expected: audio_out %0d", smp.audio_out);
				err_cnt++;
			end else begin
				want = sample_q.pop_front();
				if (want.glyph_last) n_glyphs++;
				if (smp.audio_out !== want.audio_out) begin
					$error("audio_out expected %0d got %0d", want.audio_out, smp.audio_out);
					err_cnt++;
				end
				if (smp.active !== want.active) begin
					$error("active expected %0b got %0b", want.active, smp.active);
					err_cnt++;
				end
				if (smp.glyph_last !== want.glyph_last) begin
					$error("glyph_last expected %0b got %0b", want.glyph_last,
						smp.glyph_last);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (smp_valid && !smp_stall) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WD_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		smp_stall = 1'b0;
		err_cnt = 0;
		n_loads = 0;
		n_ticks = 0;
		n_samples = 0;
		n_glyphs = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int k = 0; k < 1024; k++) sine_lut[k] = sine_value(32'(k) << 22);
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_width_shrink();
		test_backpressure();
		test_random(420, 28, 71, 4);
		test_random(420, 71, 28, 6);
		test_random(420, 0, 0, 3);

		drain();
		repeat (100) @(posedge clk);
		$display("Covered %0d loads, %0d ticks, %0d samples checked, %0d glyphs finished",
			n_loads, n_ticks, n_samples, n_glyphs);
		$display("with width shrink, register extremes and long output back-pressure");
		if (err_cnt == 0 && sample_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/gtss_pkg.sv
hdl/gtss_ctrl.sv
hdl/gtss_dp.sv
hdl/glyph_to_sine_bank_synth_unit.sv
bench/glyph_to_sine_bank_synth_unit_tb.sv
